>>> rtl/dgam_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the directed graph adjacency matrix block.
// Depends on nothing; imported by the controller, datapath and top level.
package dgam_pkg;

	// Operation codes carried in op
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_TEST   = 3'd2;
	localparam logic [2:0] OP_SUCC   = 3'd3;
	localparam logic [2:0] OP_PRED   = 3'd4;
	localparam logic [2:0] OP_DEGREE = 3'd5;

	// Status codes carried in status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	// At most this many result words per list operation
	localparam int RESULT_LIMIT = 16;
	localparam int FOUND_W      = 5;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;       // latch input word, clear per-item state
		logic rd_from;      // read row of from_vertex
		logic edge_commit;  // finish add/remove/test, load result word
		logic start_sweep;  // latch queried row, read row 0
		logic sweep_step;   // consume one row of the sweep
		logic emit_final;   // load closing result word
	} dgam_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic edge_op;      // op is add, remove or test
		logic sweep_op;     // list or degree op on a vertex in range
		logic need_emit;    // sweep step must push the pending neighbour out
		logic sweep_end;    // this step is the last one of the sweep
		logic out_free;     // output register can take a word this cycle
	} dgam_sts_t;

endpackage

>>> rtl/directed_graph_adjacency_matrix_core.sv
`timescale 1ns / 1ps
// Directed graph adjacency matrix core: edge store, edge counter and queries.
// Holds the edge matrix in a RAM with per-row valid bits.
// Input channel (in_valid/in_ready) takes one word: op, from_vertex, to_vertex.
// Output channel (out_valid/out_ready) returns result words; last marks the
// final word of an item. List ops return one word per neighbour in ascending
// order (at most 16), or one empty word.
// One item is in flight at a time; in_ready is high only when the core is idle.
// Add/remove/test read the from_vertex row, then put out their word. List and
// degree ops sweep the active rows one per cycle while the output does not
// stall, as set by the single RAM read port, then put out the closing word.
// List and degree ops on an out-of-range vertex, and unused codes, skip the
// sweep and return only the closing word.
// cfg_we writes the vertex count at once; write it only while idle.
// Reset clears the edge count, the row valid bits (matrix reads as empty)
// and sets the vertex count to 16; no clearing pass is needed.
// When the receiver stalls, the current word holds in the output register and
// the sweep waits on the next neighbour it finds.
module directed_graph_adjacency_matrix_core
	import dgam_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [4:0] from_vertex,
	input  logic [4:0] to_vertex,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic       edge_present,
	output logic       has_neighbour,
	output logic [4:0] neighbour_vertex,
	output logic [4:0] in_degree,
	output logic [4:0] out_degree,
	output logic [8:0] edge_total,
	output logic       last
);

	dgam_cmd_t cmd;
	dgam_sts_t sts;

	// sequencer
	dgam_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// storage and result path
	dgam_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.op              (op),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.status          (status),
		.edge_present    (edge_present),
		.has_neighbour   (has_neighbour),
		.neighbour_vertex(neighbour_vertex),
		.in_degree       (in_degree),
		.out_degree      (out_degree),
		.edge_total      (edge_total),
		.last            (last)
	);

endmodule

>>> rtl/dgam_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dgam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/dgam_dp.sv
`timescale 1ns / 1ps
// Datapath: vertex count register, edge matrix RAM with row valid bits,
// sweep counters and the output register. Depends on dgam_pkg and dgam_ram.
module dgam_dp
	import dgam_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic [2:0] op,
	input  logic [4:0] from_vertex,
	input  logic [4:0] to_vertex,
	input  dgam_cmd_t  cmd,
	output dgam_sts_t  sts,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [1:0] status,
	output logic       edge_present,
	output logic       has_neighbour,
	output logic [4:0] neighbour_vertex,
	output logic [4:0] in_degree,
	output logic [4:0] out_degree,
	output logic [8:0] edge_total,
	output logic       last
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [4:0]              vcount_q;
	logic [2:0]              op_q;
	logic [4:0]              from_q;
	logic [4:0]              to_q;
	logic [NW-1:0]           size;
	logic                    from_ok;
	logic                    to_ok;
	logic                    pair_ok;
	logic [VW-1:0]           from_idx;
	logic [VW-1:0]           to_idx;
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic                    rd_valid_q;
	logic                    ram_we;
	logic [MAX_VERTICES-1:0] ram_wdata;
	logic                    ram_re;
	logic [VW-1:0]           ram_raddr;
	logic [MAX_VERTICES-1:0] ram_rdata;
	logic [MAX_VERTICES-1:0] row;
	logic [MAX_VERTICES-1:0] rowv_q;
	logic [MAX_VERTICES-1:0] head_mask;
	logic                    present;
	logic [8:0]              edge_cnt_q;
	logic [8:0]              edge_cnt_next;
	logic [1:0]              edge_status;
	logic [VW-1:0]           idx_q;
	logic                    succ_bit;
	logic                    pred_bit;
	logic                    hit;
	logic                    last_index;
	logic                    cap_hit;
	logic [FOUND_W-1:0]      found_q;
	logic                    pend_valid_q;
	logic [NW-1:0]           pend_vtx_q;
	logic [NW-1:0]           indeg_q;
	logic [NW-1:0]           outdeg_q;
	logic                    emit_pend;
	logic                    load;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 5'd16;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// input word latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			from_q <= from_vertex;
			to_q   <= to_vertex;
		end
	end

	// active size and range checks
	always_comb begin
		if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
			size = NW'(MAX_VERTICES);
		end else begin
			size = NW'(vcount_q);
		end
		from_ok  = (from_q != 5'd0) && (32'(from_q) <= 32'(size));
		to_ok    = (to_q != 5'd0) && (32'(to_q) <= 32'(size));
		pair_ok  = from_ok && to_ok;
		from_idx = VW'(from_q - 5'd1);
		to_idx   = VW'(to_q - 5'd1);
	end

	// matrix storage, one row per tail vertex
	dgam_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(from_idx),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read address: queried row, or next row of the sweep
	always_comb begin
		ram_re = cmd.rd_from | cmd.start_sweep | (cmd.sweep_step & ~sts.sweep_end);
		if (cmd.rd_from) begin
			ram_raddr = from_idx;
		end else if (cmd.start_sweep) begin
			ram_raddr = '0;
		end else begin
			ram_raddr = idx_q + VW'(1);
		end
	end

	// row valid bits; a row never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ram_we) begin
				row_valid_q[from_idx] <= 1'b1;
			end
			if (ram_re) begin
				rd_valid_q <= row_valid_q[ram_raddr];
			end
		end
	end

	assign row = rd_valid_q ? ram_rdata : '0;

	// edge operations
	always_comb begin
		head_mask     = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << to_idx;
		present       = pair_ok && row[to_idx];
		ram_we        = 1'b0;
		ram_wdata     = row | head_mask;
		edge_cnt_next = edge_cnt_q;
		edge_status   = ST_OK;
		case (op_q)
			OP_ADD: begin
				if (present) begin
					edge_status = ST_DUP;
				end else if (pair_ok) begin
					ram_we        = cmd.edge_commit;
					edge_cnt_next = edge_cnt_q + 9'd1;
				end
			end
			OP_REMOVE: begin
				ram_wdata = row & ~head_mask;
				if (present) begin
					ram_we        = cmd.edge_commit;
					edge_cnt_next = edge_cnt_q - 9'd1;
				end else begin
					edge_status = ST_MISSING;
				end
			end
			default: begin
			end
		endcase
	end

	// edge counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
		end else if (cmd.edge_commit) begin
			edge_cnt_q <= edge_cnt_next;
		end
	end

	// sweep decode: one neighbour candidate per step
	always_comb begin
		succ_bit   = rowv_q[idx_q];
		pred_bit   = row[from_idx];
		hit        = ((op_q == OP_SUCC) && succ_bit) || ((op_q == OP_PRED) && pred_bit);
		last_index = (32'(idx_q) + 32'd1) == 32'(size);
		cap_hit    = hit && (found_q == FOUND_W'(RESULT_LIMIT - 1));
		emit_pend  = cmd.sweep_step && hit && pend_valid_q;
	end

	// sweep registers
	always_ff @(posedge clk) begin
		if (cmd.start_sweep) begin
			rowv_q <= row;
		end
		if (cmd.start_sweep) begin
			idx_q <= '0;
		end else if (cmd.sweep_step) begin
			idx_q <= idx_q + VW'(1);
		end
		if (cmd.sweep_step && hit) begin
			pend_vtx_q <= NW'(idx_q) + NW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= '0;
			pend_valid_q <= 1'b0;
			indeg_q      <= '0;
			outdeg_q     <= '0;
		end else if (cmd.accept) begin
			found_q      <= '0;
			pend_valid_q <= 1'b0;
			indeg_q      <= '0;
			outdeg_q     <= '0;
		end else if (cmd.sweep_step) begin
			if (hit) begin
				found_q      <= found_q + FOUND_W'(1);
				pend_valid_q <= 1'b1;
			end
			if (op_q == OP_DEGREE) begin
				indeg_q  <= indeg_q + NW'(pred_bit);
				outdeg_q <= outdeg_q + NW'(succ_bit);
			end
		end
	end

	// status to controller
	always_comb begin
		sts.edge_op   = op_q inside {OP_ADD, OP_REMOVE, OP_TEST};
		sts.sweep_op  = (op_q inside {OP_SUCC, OP_PRED, OP_DEGREE}) && from_ok;
		sts.need_emit = hit && pend_valid_q;
		sts.sweep_end = last_index || cap_hit;
		sts.out_free  = ~out_valid | out_ready;
	end

	assign load = cmd.edge_commit | emit_pend | cmd.emit_final;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status           <= ST_OK;
			edge_present     <= 1'b0;
			has_neighbour    <= 1'b0;
			neighbour_vertex <= 5'd0;
			in_degree        <= 5'd0;
			out_degree       <= 5'd0;
			edge_total       <= edge_cnt_q;
			last             <= 1'b1;
			if (cmd.edge_commit) begin
				status       <= edge_status;
				edge_present <= (op_q == OP_TEST) && present;
				edge_total   <= edge_cnt_next;
			end else if (emit_pend) begin
				has_neighbour    <= 1'b1;
				neighbour_vertex <= 5'(pend_vtx_q);
				last             <= 1'b0;
			end else begin
				has_neighbour    <= pend_valid_q;
				neighbour_vertex <= pend_valid_q ? 5'(pend_vtx_q) : 5'd0;
				in_degree        <= 5'(indeg_q);
				out_degree       <= 5'(outdeg_q);
			end
		end
	end

endmodule

>>> rtl/dgam_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences the edge access, the row sweep and
// the result words. Depends on dgam_pkg.
module dgam_ctrl
	import dgam_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dgam_sts_t sts,
	output dgam_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_EDGE  = 3'd2;
	localparam logic [2:0] S_LATCH = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;

	// next state and commands
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_next = S_READ;
				end
			end
			S_READ: begin
				if (sts.edge_op) begin
					cmd.rd_from = 1'b1;
					state_next  = S_EDGE;
				end else if (sts.sweep_op) begin
					cmd.rd_from = 1'b1;
					state_next  = S_LATCH;
				end else begin
					state_next = S_DONE;
				end
			end
			S_EDGE: begin
				if (sts.out_free) begin
					cmd.edge_commit = 1'b1;
					state_next      = S_IDLE;
				end
			end
			S_LATCH: begin
				cmd.start_sweep = 1'b1;
				state_next      = S_SWEEP;
			end
			S_SWEEP: begin
				// stall only when a neighbour must go out and the output is full
				if (!sts.need_emit || sts.out_free) begin
					cmd.sweep_step = 1'b1;
					if (sts.sweep_end) begin
						state_next = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_next     = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

>>> rtl/dgam_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the adjacency matrix core, plus its bind.
// Depends on dgam_pkg and directed_graph_adjacency_matrix_core.
module dgam_checker
	import dgam_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic       edge_present,
	input logic       has_neighbour,
	input logic [4:0] neighbour_vertex,
	input logic       last
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	// a word that is not last leaves the item open
	a_list_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken before the last word of a list");

	// a listed neighbour is a real vertex and carries no edge status
	a_nb_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_neighbour |-> neighbour_vertex != 5'd0 && status == ST_OK
			&& !edge_present)
		else $error("malformed neighbour word");

endmodule

bind directed_graph_adjacency_matrix_core dgam_checker u_chk (.*);
